/* rtl/mafs_pkg.sv */
// Package: shared widths, header decode record and stream constants for the frame sync block.
package mafs_pkg;

    localparam int LENGTH_BITS = 11;
    localparam int BYTE_W      = 8;
    localparam int BR_W        = 19;
    localparam int SR_W        = 16;
    localparam int BASE_W      = 8;
    localparam int PAD_W       = 3;
    localparam int PROD_W      = BASE_W + BR_W;
    localparam int CNT_W       = $clog2(PROD_W + 1);
    localparam int OUT_LEN_W   = 11;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 64;
    localparam int M_USER_W    = 2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_MASK = 8'hE0;

    typedef struct packed {
        logic              ok;
        logic [BR_W-1:0]   bit_rate;
        logic [SR_W-1:0]   freq_hz;
        logic [BASE_W-1:0] base;
        logic [PAD_W-1:0]  pad_slot;
        logic              is_mpeg2;
        logic [1:0]        layer_code;
    } t_hdr;

endpackage

/* rtl/mafs_hdr_dec.sv */
// Header decoder: sync check and the bitrate, sample-rate and base tables.
module mafs_hdr_dec (
    input  logic [mafs_pkg::BYTE_W-1:0] i_b0,
    input  logic [mafs_pkg::BYTE_W-1:0] i_b1,
    input  logic [mafs_pkg::BYTE_W-1:0] i_b2,
    output mafs_pkg::t_hdr              o_hdr
);
    import mafs_pkg::*;

    logic [1:0]        ver;
    logic [1:0]        layer;
    logic [3:0]        brc;
    logic [1:0]        src;
    logic              pad;
    logic              sync;
    logic [BR_W-1:0]   br;
    logic [SR_W-1:0]   sr;
    logic [BASE_W-1:0] base;

    assign ver   = i_b1[4:3];
    assign layer = i_b1[2:1];
    assign brc   = i_b2[7:4];
    assign src   = i_b2[3:2];
    assign pad   = i_b2[1];
    assign sync  = (i_b0 == SYNC_BYTE) && ((i_b1 & SYNC_MASK) == SYNC_MASK);

    always_comb begin
        unique case ({brc, ver, layer})
            8'h1F, 8'h1E, 8'h1D, 8'h1B: br = 19'd32000;
            8'h6F, 8'hAE, 8'hBD, 8'hCB: br = 19'd192000;
            8'hAF, 8'hDE, 8'hED:        br = 19'd320000;
            default:                    br = '0;
        endcase
    end

    always_comb begin
        unique case ({src, ver})
            4'h3:    sr = 16'd44100;
            4'h7:    sr = 16'd48000;
            4'hB:    sr = 16'd32000;
            4'h2:    sr = 16'd22050;
            4'h6:    sr = 16'd24000;
            4'hA:    sr = 16'd16000;
            default: sr = '0;
        endcase
    end

    always_comb begin
        priority if (layer == 2'd3 && (ver == 2'd3 || ver == 2'd2)) begin
            base = 8'd48;
        end else if (ver == 2'd3 && (layer == 2'd2 || layer == 2'd1)) begin
            base = 8'd144;
        end else begin
            base = '0;
        end
    end

    always_comb begin
        o_hdr.ok          = sync && (br != '0) && (sr != '0) && (base != '0);
        o_hdr.bit_rate    = br;
        o_hdr.freq_hz     = sr;
        o_hdr.base        = base;
        o_hdr.pad_slot    = pad ? ((layer == 2'd3) ? 3'd4 : 3'd1) : 3'd0;
        o_hdr.is_mpeg2    = (ver == 2'd2);
        o_hdr.layer_code  = layer;
    end

endmodule

/* rtl/mafs_div.sv */
// Restoring divider: one quotient bit per cycle over the product width.
module mafs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mafs_pkg::PROD_W-1:0] i_dividend,
    input  logic [mafs_pkg::SR_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [mafs_pkg::PROD_W-1:0] o_quotient
);
    import mafs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_dvd;
    logic [SR_W-1:0]   r_rem;
    logic [SR_W-1:0]   r_dvs;
    logic [SR_W:0]     n_rem_sh;
    logic              n_ge;

    assign n_rem_sh = {r_rem, r_dvd[PROD_W-1]};
    assign n_ge     = (n_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[PROD_W-2:0], n_ge};
                r_rem <= n_ge ? SR_W'(n_rem_sh - {1'b0, r_dvs}) : n_rem_sh[SR_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

/* rtl/mpeg_audio_frame_sync_top.sv */
// Top level: byte window, header sequencer, frame pass-through and output register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] in_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tlast = frame_last, m_tuser flags
//
// A byte that is stored, dropped or passed through is handled in the cycle that it is accepted.
// An accepted header goes through S_START, S_DIV with the 27-step divider, and S_EMIT for its four bytes.
// Reset is synchronous and clears control state; there is no clearing pass.
// While the output register is full and m_tready is low, no request is taken.
module mpeg_audio_frame_sync_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] in_byte
    input  logic [mafs_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] out_byte, [18:8] frame_length, [37:19] bit_rate, [53:38] freq_hz,
    // [54] is_mpeg2, [56:55] layer_code, [63:57] zero
    output logic [mafs_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    // [0] frame_first, [1] burst_last
    output logic [mafs_pkg::M_USER_W-1:0] m_tuser
);
    import mafs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [BYTE_W-1:0]      r_win [0:2];
    logic [BYTE_W-1:0]      r_b3;
    logic [1:0]             r_fill;
    logic                   r_in_frame;
    logic [LENGTH_BITS-1:0] r_left;
    logic [1:0]             r_k;
    logic [PROD_W-1:0]      r_prod;
    logic [PAD_W-1:0]       r_pad;
    logic [LENGTH_BITS-1:0] r_len;
    logic [BR_W-1:0]        r_br;
    logic [SR_W-1:0]        r_sr;
    logic                   r_mp2;
    logic [1:0]             r_layer;

    logic                   r_m_valid;
    logic [BYTE_W-1:0]      r_o_byte;
    logic                   r_o_first;
    logic                   r_o_last;
    logic                   r_o_burst;
    logic [LENGTH_BITS-1:0] r_o_len;
    logic [BR_W-1:0]        r_o_br;
    logic [SR_W-1:0]        r_o_sr;
    logic                   r_o_mp2;
    logic [1:0]             r_o_layer;

    t_hdr                   hdr;
    logic                   div_done;
    logic [PROD_W-1:0]      div_q;
    logic                   slot_free;
    logic                   s_acc;
    logic                   out_load;
    logic [PROD_W:0]        n_sum;
    logic [LENGTH_BITS-1:0] n_len;
    logic [LENGTH_BITS-1:0] n_left;
    logic [LENGTH_BITS-1:0] n_dec;
    logic [BYTE_W-1:0]      n_hb;

    mafs_hdr_dec u_dec (
        .i_b0  (r_win[0]),
        .i_b1  (r_win[1]),
        .i_b2  (r_win[2]),
        .o_hdr (hdr)
    );

    mafs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (r_prod),
        .i_divisor  (r_sr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign slot_free = !r_m_valid || m_tready;
    assign s_tready  = (r_state == S_IDLE) && slot_free;
    assign s_acc     = s_tvalid && s_tready;
    assign out_load  = ((r_state == S_IDLE) && s_acc && r_in_frame) ||
                       ((r_state == S_EMIT) && slot_free);

    assign n_sum  = {1'b0, div_q} + (PROD_W + 1)'(r_pad);
    assign n_len  = (n_sum > (PROD_W + 1)'({LENGTH_BITS{1'b1}})) ? '1 : n_sum[LENGTH_BITS-1:0];
    assign n_left = (n_len >= LENGTH_BITS'(4)) ? (n_len - LENGTH_BITS'(4)) : '0;
    assign n_dec  = r_left - 1'b1;

    always_comb begin
        unique case (r_k)
            2'd0:    n_hb = r_win[0];
            2'd1:    n_hb = r_win[1];
            2'd2:    n_hb = r_win[2];
            default: n_hb = r_b3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_in_frame <= 1'b0;
            r_left     <= '0;
            r_k        <= '0;
            r_m_valid  <= 1'b0;
            r_len      <= '0;
            r_br       <= '0;
            r_sr       <= '0;
            r_mp2      <= 1'b0;
            r_layer    <= '0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (r_in_frame) begin
                            r_left    <= n_dec;
                            r_o_byte  <= s_tdata;
                            r_o_first <= 1'b0;
                            r_o_last  <= (n_dec == '0);
                            r_o_burst <= 1'b1;
                            r_o_len   <= r_len;
                            r_o_br    <= r_br;
                            r_o_sr    <= r_sr;
                            r_o_mp2   <= r_mp2;
                            r_o_layer <= r_layer;
                            if (n_dec == '0) begin
                                r_in_frame <= 1'b0;
                                r_fill     <= '0;
                            end
                        end else if (r_fill != 2'd3) begin
                            r_win[r_fill] <= s_tdata;
                            r_fill        <= r_fill + 1'b1;
                        end else if (hdr.ok) begin
                            r_b3    <= s_tdata;
                            r_prod  <= PROD_W'(hdr.base) * PROD_W'(hdr.bit_rate);
                            r_pad   <= hdr.pad_slot;
                            r_br    <= hdr.bit_rate;
                            r_sr    <= hdr.freq_hz;
                            r_mp2   <= hdr.is_mpeg2;
                            r_layer <= hdr.layer_code;
                            r_fill  <= '0;
                            r_state <= S_START;
                        end else begin
                            r_win[0] <= r_win[1];
                            r_win[1] <= r_win[2];
                            r_win[2] <= s_tdata;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_len   <= n_len;
                        r_left  <= n_left;
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_o_byte  <= n_hb;
                        r_o_first <= (r_k == 2'd0);
                        r_o_last  <= (r_k == 2'd3) && (r_left == '0);
                        r_o_burst <= (r_k == 2'd3);
                        r_o_len   <= r_len;
                        r_o_br    <= r_br;
                        r_o_sr    <= r_sr;
                        r_o_mp2   <= r_mp2;
                        r_o_layer <= r_layer;
                        r_k       <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            r_in_frame <= (r_left != '0);
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tlast  = r_o_last;
    assign m_tuser  = {r_o_burst, r_o_first};
    assign m_tdata  = {7'b0, r_o_layer, r_o_mp2, r_o_sr, r_o_br,
                       r_o_len[OUT_LEN_W-1:0], r_o_byte};

`ifndef SYNTHESIS
    a_frame_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_in_frame) |-> (r_left != '0))
        else $error("in frame with no bytes left");
    a_emit_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_in_frame)
        else $error("header sequence runs during a frame");
    a_first_is_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == SYNC_BYTE && !m_tlast))
        else $error("frame start byte is not a sync byte");
`endif

endmodule
